/* rtl/llcm_pkg.sv */
// Shared types and constants for the list LCM block.
// Depends on nothing; every other file imports it.
package llcm_pkg;

  // Data word width and the bit count of a divider step counter
  localparam int DW    = 32;
  localparam int CNT_W = $clog2(DW);

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // store the accepted item
    logic clear_list;  // end of list: drop count and flags
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic ld_r;        // r <= store[i]
    logic gcd_start;   // g <= gcd(r, fresh[j])
    logic div_start;   // start r / g
    logic r_div;       // r <= quotient
    logic mul;         // fresh[i] <= r, prod <= wrapped * r
    logic acc_init;    // wrapped <= 1, overflow cleared
    logic acc;         // wrapped <= low half of prod, track overflow
    logic out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad_now;     // list is overfull or holds a zero, this item included
    logic i_zero;
    logic i_last;      // i is the last stored index
    logic j_next_eq_i; // j + 1 reaches i
    logic gcd_done;
    logic g_one;
    logic div_done;
    logic out_free;    // result register can take a new transaction
  } sts_t;

endpackage

/* rtl/llcm_item_if.sv */
// Input channel: one list value per transaction, with the end-of-list flag.
// Depends on llcm_pkg.
interface llcm_item_if import llcm_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] value;
  logic          last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

/* rtl/llcm_result_if.sv */
// Output channel: one LCM and its status per transaction.
// Depends on llcm_pkg.
interface llcm_result_if import llcm_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] lcm;
  logic [1:0]    status;

  modport source (output valid, lcm, status, input ready);
  modport sink   (input valid, lcm, status, output ready);
endinterface

/* rtl/llcm_gcd.sv */
// Binary (shift and subtract) GCD unit, one step per cycle.
// Depends on llcm_pkg. Both operands must be nonzero.
module llcm_gcd import llcm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] a_in,
  input  logic [DW-1:0] b_in,
  output logic          done,
  output logic [DW-1:0] g
);

  logic [DW-1:0]    a;
  logic [DW-1:0]    b;
  logic [CNT_W-1:0] k;     // common factors of two
  logic             busy;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (a == b)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand reduction
  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (busy) begin
      priority if (a == b) begin
        g <= a << k;
      end else if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a > b) begin
        a <= (a - b) >> 1;
      end else begin
        b <= (b - a) >> 1;
      end
    end
  end

endmodule

/* rtl/llcm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on llcm_pkg. Divisor must be nonzero.
module llcm_div import llcm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, quo[DW-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/llcm_dp.sv */
// Datapath: value store, fresh-part store, index counters, GCD and divider
// units, product register and result register. Depends on llcm_pkg,
// llcm_gcd and llcm_div.
module llcm_dp import llcm_pkg::*; #(
  parameter int MAX_VALUES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [DW-1:0] in_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_lcm,
  output logic [1:0]    out_status
);

  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam int IW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

  logic [DW-1:0]   value_store [MAX_VALUES];
  logic [DW-1:0]   fresh_store [MAX_VALUES];
  logic [DW-1:0]   store_rdata;
  logic [DW-1:0]   fresh_rdata;
  logic [CW-1:0]   count;
  logic            zero_seen;
  logic            overfull;
  logic            store_full;
  logic [IW-1:0]   i;
  logic [IW-1:0]   j;
  logic [DW-1:0]   r;
  logic [DW-1:0]   g;
  logic [DW-1:0]   quo;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   wrapped;
  logic            ovf;

  assign store_full = (count == CW'(MAX_VALUES));

  // List bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      zero_seen <= 1'b0;
      overfull  <= 1'b0;
    end else if (cmd.clear_list) begin
      count     <= '0;
      zero_seen <= 1'b0;
      overfull  <= 1'b0;
    end else if (cmd.load) begin
      if (in_value == '0) zero_seen <= 1'b1;
      if (store_full) overfull <= 1'b1;
      else            count    <= count + 1'b1;
    end
  end

  // Value store: written on load, read at i
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) value_store[count[IW-1:0]] <= in_value;
    store_rdata <= value_store[i];
  end

  // Fresh-part store: written at i, read at j
  always_ff @(posedge clk) begin
    if (cmd.mul) fresh_store[i] <= r;
    fresh_rdata <= fresh_store[j];
  end

  // Index counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      if (cmd.i_clr)      i <= '0;
      else if (cmd.i_inc) i <= i + 1'b1;
      if (cmd.j_clr)      j <= '0;
      else if (cmd.j_inc) j <= j + 1'b1;
    end
  end

  // Working value: loaded from the store, reduced by each quotient
  always_ff @(posedge clk) begin
    if (cmd.ld_r)       r <= store_rdata;
    else if (cmd.r_div) r <= quo;
  end

  llcm_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.gcd_start),
    .a_in  (r),
    .b_in  (fresh_rdata),
    .done  (sts.gcd_done),
    .g     (g)
  );

  llcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (r),
    .divisor  (g),
    .done     (sts.div_done),
    .quo      (quo)
  );

  // Running product; wrapped equals the exact product until overflow
  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= (2*DW)'(wrapped) * (2*DW)'(r);
    if (cmd.acc_init) begin
      wrapped <= DW'(1);
      ovf     <= 1'b0;
    end else if (cmd.acc) begin
      wrapped <= prod[DW-1:0];
      if (prod[2*DW-1:DW] != '0) ovf <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      priority if (overfull) begin
        out_lcm    <= '0;
        out_status <= ST_TOO_MANY;
      end else if (zero_seen) begin
        out_lcm    <= '0;
        out_status <= ST_ZERO;
      end else begin
        out_lcm    <= wrapped;
        out_status <= ovf ? ST_OVERFLOW : ST_OK;
      end
    end
  end

  // Status to the controller
  assign sts.bad_now     = overfull || zero_seen || (in_value == '0) || store_full;
  assign sts.i_zero      = (i == '0);
  assign sts.i_last      = ((CW'(i) + CW'(1)) == count);
  assign sts.j_next_eq_i = (({1'b0, j} + 1'b1) == {1'b0, i});
  assign sts.g_one       = (g == DW'(1));
  assign sts.out_free    = !out_valid || out_ready;

endmodule

/* rtl/llcm_ctrl.sv */
// Controller: sequences loading, the per-value GCD/divide reduction, the
// product accumulation and the result hand-off. Depends on llcm_pkg.
module llcm_ctrl import llcm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [11:0] {
    S_LOAD     = 12'b0000_0000_0001,
    S_START    = 12'b0000_0000_0010,
    S_RD_I     = 12'b0000_0000_0100,
    S_LD_R     = 12'b0000_0000_1000,
    S_RD_F     = 12'b0000_0001_0000,
    S_GCD_GO   = 12'b0000_0010_0000,
    S_GCD_WAIT = 12'b0000_0100_0000,
    S_DIV_WAIT = 12'b0000_1000_0000,
    S_NEXT_J   = 12'b0001_0000_0000,
    S_MUL      = 12'b0010_0000_0000,
    S_ACC      = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  assign in_ready = (state == S_LOAD);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = sts.bad_now ? S_EMIT : S_START;
        end
      end
      S_START: begin
        cmd.i_clr    = 1'b1;
        cmd.acc_init = 1'b1;
        state_next   = S_RD_I;
      end
      S_RD_I: state_next = S_LD_R;
      S_LD_R: begin
        cmd.ld_r   = 1'b1;
        cmd.j_clr  = 1'b1;
        state_next = sts.i_zero ? S_MUL : S_RD_F;
      end
      S_RD_F: state_next = S_GCD_GO;
      S_GCD_GO: begin
        cmd.gcd_start = 1'b1;
        state_next    = S_GCD_WAIT;
      end
      S_GCD_WAIT: begin
        if (sts.gcd_done) begin
          if (sts.g_one) begin
            state_next = S_NEXT_J;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV_WAIT;
          end
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.r_div  = 1'b1;
          state_next = S_NEXT_J;
        end
      end
      S_NEXT_J: begin
        cmd.j_inc  = 1'b1;
        state_next = sts.j_next_eq_i ? S_MUL : S_RD_F;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        cmd.i_inc  = 1'b1;
        state_next = sts.i_last ? S_EMIT : S_RD_I;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.clear_list = 1'b1;
          state_next     = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

/* rtl/list_lowest_common_multiple.sv */
// List LCM. Values load at one transaction per cycle. After the last value, input
// is not ready: a start step; per value i, a read and load of r, then per
// earlier value j, a read of its fresh part, a binary GCD and, if it is not 1,
// a divide; then a multiply and accumulate; last, output (held while the result
// is full). A zero or too-many list skips straight to output. Synchronous reset
// clears controller, list count, flags and result valid; stores need no clear.
module list_lowest_common_multiple import llcm_pkg::*; #(
  parameter int MAX_VALUES = 16
) (
  input  logic          clk,
  input  logic          rst,
  llcm_item_if.sink     item,
  llcm_result_if.source result
);

  cmd_t cmd;
  sts_t sts;

  llcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_last  (item.last),
    .in_ready (item.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  llcm_dp #(
    .MAX_VALUES (MAX_VALUES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (item.value),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_lcm    (result.lcm),
    .out_status (result.status)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for list_lowest_common_multiple.
// Depends on llcm_pkg, llcm_item_if, llcm_result_if and the block itself.
// Predicts or pins each list LCM and checks every result transaction in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import llcm_pkg::*;

  localparam int MAX_VALUES    = 16;
  localparam int TOTAL_ITEMS   = 1850;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [DW-1:0] lcm;
    logic [1:0]    status;
  } lcm_result_t;

  // One directed row: value sent reps times, last only on the final copy
  typedef struct packed {
    logic [DW-1:0] value;
    logic [7:0]    reps;
    logic          last;
    logic          pinned;
    lcm_result_t   want;
  } stim_row_t;

  logic clk;
  logic rst;

  llcm_item_if   item_ch ();
  llcm_result_if result_ch ();

  list_lowest_common_multiple #(
    .MAX_VALUES(MAX_VALUES)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  // Predictor copy of the list being collected
  logic [DW-1:0] list_store [MAX_VALUES];
  int unsigned   list_count;
  bit            list_zero;
  bit            list_overfull;

  lcm_result_t   lcm_expected [$];
  stim_row_t     stim_table [$];

  int unsigned items_sent;
  int unsigned lists_sent;
  int unsigned results_seen;
  int unsigned status_seen [4];
  int unsigned mismatch_count;
  bit          sender_burst;
  bit          sink_burst;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(100_000_000);
    $display("Timeout with %0d results still pending", lcm_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [DW-1:0] gcd_u32(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // LCM of the collected list: product of each value's part not already covered
  function automatic lcm_result_t list_lcm();
    lcm_result_t   res;
    logic [DW-1:0] fresh [MAX_VALUES];
    logic [DW-1:0] r;
    logic [63:0]   exact;
    logic [63:0]   prod;
    bit            ovf;
    res.lcm    = '0;
    res.status = ST_OK;
    if (list_overfull) begin
      res.status = ST_TOO_MANY;
    end else if (list_zero) begin
      res.status = ST_ZERO;
    end else begin
      res.lcm = 1;
      exact   = 64'd1;
      ovf     = 1'b0;
      for (int i = 0; i < list_count; i++) begin
        r = list_store[i];
        for (int j = 0; j < i; j++) r = r / gcd_u32(r, fresh[j]);
        fresh[i] = r;
        prod     = {32'b0, res.lcm} * {32'b0, r};
        res.lcm  = prod[DW-1:0];
        if (!ovf) begin
          exact = exact * {32'b0, r};
          if (exact > 64'h0000_0000_FFFF_FFFF) ovf = 1'b1;
        end
      end
      res.status = ovf ? ST_OVERFLOW : ST_OK;
    end
    return res;
  endfunction

  // Fold an accepted value into the predictor; close the list on last
  task automatic take_value(input logic [DW-1:0] v, input logic lst,
                            input bit pinned, input lcm_result_t pinned_res);
    if (v == 0) list_zero = 1'b1;
    if (list_count < MAX_VALUES) begin
      list_store[list_count] = v;
      list_count++;
    end else begin
      list_overfull = 1'b1;
    end
    if (lst) begin
      lcm_expected.push_back(pinned ? pinned_res : list_lcm());
      list_count    = 0;
      list_zero     = 1'b0;
      list_overfull = 1'b0;
      lists_sent++;
    end
  endtask

  // Offer one value after a random gap and wait for the transaction
  task automatic send_value(input logic [DW-1:0] v, input logic lst,
                            input bit pinned, input lcm_result_t pinned_res);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.last  <= lst;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    take_value(v, lst, pinned, pinned_res);
  endtask

  task automatic add_row(input logic [DW-1:0] v, input int unsigned reps, input logic lst,
                         input bit pinned, input logic [DW-1:0] lcm, input logic [1:0] st);
    stim_row_t row;
    row.value       = v;
    row.reps        = reps[7:0];
    row.last        = lst;
    row.pinned      = pinned;
    row.want.lcm    = lcm;
    row.want.status = st;
    stim_table.push_back(row);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Random list value: mostly values with shared small factors
  function automatic logic [DW-1:0] draw_value();
    int unsigned   kind;
    logic [DW-1:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      v = $urandom_range(1, 64);
    end else if (kind < 60) begin
      v = 1;
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0: v = v * 2;
          1: v = v * 3;
          2: v = v * 5;
          3: v = v * 7;
          4: v = v * 11;
          default: v = v * 13;
        endcase
      end
    end else if (kind < 82) begin
      v = $urandom;
    end else if (kind < 90) begin
      v = 32'h1 << $urandom_range(0, 31);
    end else if (kind < 97) begin
      v = 32'hFFFF_FFFF - $urandom_range(0, 255);
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // Stimulus: directed table, then random lists
  initial begin : stimulus
    int unsigned len;
    int unsigned sel;
    lcm_result_t none;
    stim_row_t   row;
    none           = '0;
    rst            = 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.value <= '0;
    item_ch.last  <= 1'b0;
    list_count     = 0;
    list_zero      = 1'b0;
    list_overfull  = 1'b0;
    sender_burst   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: extremes and each special case
    add_row(32'hFFFF_FFFF, 1, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_OK);   // single max value
    add_row(32'd1,         1, 1'b1, 1'b1, 32'd1,         ST_OK);   // single one
    add_row(32'd0,         1, 1'b1, 1'b1, 32'd0,         ST_ZERO); // single zero
    add_row(32'd1,         3, 1'b1, 1'b1, 32'd1,         ST_OK);   // all ones
    add_row(32'd12,        1, 1'b0, 1'b0, '0,            ST_OK);
    add_row(32'd18,        1, 1'b1, 1'b1, 32'd36,        ST_OK);
    add_row(32'd5,         1, 1'b0, 1'b0, '0,            ST_OK);   // zero after a value
    add_row(32'd0,         1, 1'b1, 1'b1, 32'd0,         ST_ZERO);
    add_row(32'hFFFF_FFFF, 1, 1'b0, 1'b0, '0,            ST_OK);   // wraps past 32 bits
    add_row(32'hFFFF_FFFE, 1, 1'b1, 1'b0, '0,            ST_OK);
    add_row(32'd1,        16, 1'b0, 1'b0, '0,            ST_OK);   // fill the store
    add_row(32'd0,         1, 1'b1, 1'b1, 32'd0,         ST_TOO_MANY); // overfull beats zero

    foreach (stim_table[r]) begin
      row = stim_table[r];
      for (int k = 0; k < row.reps; k++)
        send_value(row.value, row.last && (k == row.reps - 1), row.pinned, row.want);
    end

    // Random lists, mostly short; a few fill or overrun the store
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) sender_burst = !sender_burst;
      if (lists_sent % 97 == 50) begin
        // Let the block drain completely before the next list
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (lcm_expected.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 80)      len = $urandom_range(1, 4);
      else if (sel < 94) len = $urandom_range(5, MAX_VALUES);
      else               len = $urandom_range(MAX_VALUES + 1, MAX_VALUES + 3);
      for (int k = 0; k < len; k++)
        send_value(draw_value(), k == len - 1, 1'b0, none);
    end

    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (lcm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d values in %0d lists, %0d mismatches", items_sent, lists_sent,
             mismatch_count);
    $display("Results ok/zero/overflow/too-many: %0d/%0d/%0d/%0d", status_seen[ST_OK],
             status_seen[ST_ZERO], status_seen[ST_OVERFLOW], status_seen[ST_TOO_MANY]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result sink: random stalls, periodic long hold-off, in-order check
  initial begin : result_sink
    int unsigned gap;
    lcm_result_t got;
    lcm_result_t want;
    result_ch.ready <= 1'b0;
    sink_burst       = 1'b0;
    results_seen     = 0;
    mismatch_count   = 0;
    foreach (status_seen[s]) status_seen[s] = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) sink_burst = !sink_burst;
      if (results_seen % 150 == 30) gap = HOLD_CYCLES;
      else                          gap = sink_burst ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got.lcm    = result_ch.lcm;
      got.status = result_ch.status;
      results_seen++;
      status_seen[got.status]++;
      if (lcm_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result lcm %h status %0d", got.lcm, got.status));
      end else begin
        want = lcm_expected.pop_front();
        if (got.lcm !== want.lcm)
          flag_mismatch($sformatf("result %0d lcm expected %h got %h", results_seen,
                                  want.lcm, got.lcm));
        if (got.status !== want.status)
          flag_mismatch($sformatf("result %0d status expected %0d got %0d", results_seen,
                                  want.status, got.status));
      end
    end
  end

endmodule
